// ===== rtl/core/fmsph_pkg.sv =====
// Shared constants, types and helper functions of the four-momentum to spherical unit.
package fmsph_pkg;

	localparam int WORD_BITS    = 32;
	localparam int SQ_BITS      = 2 * WORD_BITS;
	localparam int ANGLE_BITS   = 24;
	localparam int GUARD_BITS   = 8;
	localparam int TURN_BITS    = ANGLE_BITS + GUARD_BITS;
	localparam int CORDIC_STEPS = ANGLE_BITS + 6;
	localparam int CORDIC_BITS  = 45;
	localparam int NORM_LEN     = 41;
	localparam int SQRT_STEPS   = WORD_BITS;
	localparam int PREP_LAT     = 5;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 4;
	localparam int TOTAL_LAT    = PREP_LAT + SQRT_STEPS + CORDIC_LAT;
	localparam int CHUNKS       = SQ_BITS / 8;
	localparam int BL_BITS      = 7;
	localparam int SHIFT_BITS   = 5;
	localparam int J_MAX        = WORD_BITS - 1;
	localparam int Z_LIMIT      = SQ_BITS - 2;
	localparam int IN_TDATA_BITS  = 4 * WORD_BITS;
	localparam int OUT_TDATA_BITS = 3 * WORD_BITS + 2 * ANGLE_BITS;
	localparam int OUT_TUSER_BITS = 2;

	typedef logic [TURN_BITS-1:0] turn_t;
	typedef logic [CHUNKS-1:0][3:0] chunk_bl_t;

	typedef struct packed {
		logic [SQ_BITS-1:0]          p_sq;
		logic [SQ_BITS-1:0]          pt_sq;
		logic [SQ_BITS-1:0]          mass_sq;
		logic [SQ_BITS-1:0]          ps;
		logic signed [SQ_BITS-1:0]   zpart;
		logic signed [WORD_BITS-1:0] x;
		logic signed [WORD_BITS-1:0] y;
		logic                        zero_mom;
		logic                        mass_inv;
	} prep_t;

	function automatic turn_t atan_step(input int i);
		turn_t r;
		case (i)
			0:  r = 32'd536870912;
			1:  r = 32'd316933405;
			2:  r = 32'd167458907;
			3:  r = 32'd85004756;
			4:  r = 32'd42667331;
			5:  r = 32'd21354465;
			6:  r = 32'd10679838;
			7:  r = 32'd5340245;
			8:  r = 32'd2670163;
			9:  r = 32'd1335086;
			10: r = 32'd667544;
			11: r = 32'd333772;
			12: r = 32'd166886;
			13: r = 32'd83443;
			14: r = 32'd41721;
			15: r = 32'd20860;
			16: r = 32'd10430;
			17: r = 32'd5215;
			18: r = 32'd2607;
			19: r = 32'd1303;
			20: r = 32'd651;
			21: r = 32'd325;
			22: r = 32'd162;
			23: r = 32'd81;
			24: r = 32'd40;
			25: r = 32'd20;
			26: r = 32'd10;
			27: r = 32'd5;
			28: r = 32'd2;
			29: r = 32'd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] bitlen8(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int k = 0; k < 8; k++) begin
			if (v[k]) n = 4'(k + 1);
		end
		return n;
	endfunction

	function automatic chunk_bl_t chunk_bitlens(input logic [SQ_BITS-1:0] v);
		chunk_bl_t r;
		for (int c = 0; c < CHUNKS; c++) begin
			r[c] = bitlen8(v[c*8 +: 8]);
		end
		return r;
	endfunction

	function automatic logic [BL_BITS-1:0] bitlen_join(input chunk_bl_t b);
		logic [BL_BITS-1:0] n;
		n = '0;
		for (int c = 0; c < CHUNKS; c++) begin
			if (b[c] != 4'd0) n = BL_BITS'(c * 8) + BL_BITS'(b[c]);
		end
		return n;
	endfunction

endpackage

// ===== rtl/core/fmsph_prep.sv =====
// Front stages: squares, sums, mass square, and scaling of the polar operands.
module fmsph_prep import fmsph_pkg::*; (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [WORD_BITS-1:0] mom_x,
	input  logic signed [WORD_BITS-1:0] mom_y,
	input  logic signed [WORD_BITS-1:0] mom_z,
	input  logic [WORD_BITS-1:0]        energy,
	output prep_t                       prep
);

	logic [WORD_BITS-1:0] ax, ay, az;
	logic [SQ_BITS-1:0] xx, yy, zz, ee;

	logic signed [WORD_BITS-1:0] x_s1, y_s1, z_s1;
	logic [WORD_BITS-1:0] mz_s1;
	logic [SQ_BITS-1:0] xx_s1, yy_s1, zz_s1, ee_s1;

	logic signed [WORD_BITS-1:0] x_s2, y_s2, z_s2;
	logic [WORD_BITS-1:0] mz_s2;
	logic [SQ_BITS-1:0] p_s2, pt_s2, mass_s2;
	logic zero_s2, inv_s2;

	logic signed [WORD_BITS-1:0] x_s3, y_s3, z_s3;
	logic [WORD_BITS-1:0] mz_s3;
	logic [SQ_BITS-1:0] p_s3, pt_s3, mass_s3;
	logic zero_s3, inv_s3;
	chunk_bl_t cpt_s3, cmz_s3;

	logic signed [WORD_BITS-1:0] x_s4, y_s4, z_s4;
	logic [WORD_BITS-1:0] mz_s4;
	logic [SQ_BITS-1:0] p_s4, pt_s4, mass_s4;
	logic zero_s4, inv_s4;
	logic [SHIFT_BITS-1:0] j_s4;

	logic [BL_BITS-1:0] blp, blz, kp, kz, jv;
	logic [SQ_BITS-1:0] zs;

	prep_t out_s5;

	assign ax = mom_x[WORD_BITS-1] ? (~mom_x + 1'b1) : mom_x;
	assign ay = mom_y[WORD_BITS-1] ? (~mom_y + 1'b1) : mom_y;
	assign az = mom_z[WORD_BITS-1] ? (~mom_z + 1'b1) : mom_z;
	assign xx = ax * ax;
	assign yy = ay * ay;
	assign zz = az * az;
	assign ee = energy * energy;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= mom_x;
			y_s1  <= mom_y;
			z_s1  <= mom_z;
			mz_s1 <= az;
			xx_s1 <= xx;
			yy_s1 <= yy;
			zz_s1 <= zz;
			ee_s1 <= ee;
		end
	end

	always_ff @(posedge clk) begin
		logic [SQ_BITS-1:0] pt, p;
		pt = xx_s1 + yy_s1;
		p  = pt + zz_s1;
		if (en) begin
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			z_s2    <= z_s1;
			mz_s2   <= mz_s1;
			pt_s2   <= pt;
			p_s2    <= p;
			zero_s2 <= (p == '0);
			inv_s2  <= (ee_s1 < p);
			mass_s2 <= (ee_s1 < p) ? '0 : ee_s1 - p;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			z_s3    <= z_s2;
			mz_s3   <= mz_s2;
			pt_s3   <= pt_s2;
			p_s3    <= p_s2;
			mass_s3 <= mass_s2;
			zero_s3 <= zero_s2;
			inv_s3  <= inv_s2;
			cpt_s3  <= chunk_bitlens(pt_s2);
			cmz_s3  <= chunk_bitlens(SQ_BITS'(mz_s2));
		end
	end

	always_comb begin
		blp = bitlen_join(cpt_s3);
		blz = bitlen_join(cmz_s3);
		kp  = (BL_BITS'(SQ_BITS) - blp) >> 1;
		kz  = BL_BITS'(Z_LIMIT) - blz;
		jv  = BL_BITS'(J_MAX);
		if (kp < jv) jv = kp;
		if (kz < jv) jv = kz;
		if (pt_s3 == '0) jv = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s4    <= x_s3;
			y_s4    <= y_s3;
			z_s4    <= z_s3;
			mz_s4   <= mz_s3;
			pt_s4   <= pt_s3;
			p_s4    <= p_s3;
			mass_s4 <= mass_s3;
			zero_s4 <= zero_s3;
			inv_s4  <= inv_s3;
			j_s4    <= jv[SHIFT_BITS-1:0];
		end
	end

	assign zs = SQ_BITS'(mz_s4) << j_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			out_s5.p_sq     <= p_s4;
			out_s5.pt_sq    <= pt_s4;
			out_s5.mass_sq  <= mass_s4;
			out_s5.ps       <= pt_s4 << {j_s4, 1'b0};
			out_s5.zpart    <= z_s4[WORD_BITS-1] ? -$signed(zs) : $signed(zs);
			out_s5.x        <= x_s4;
			out_s5.y        <= y_s4;
			out_s5.zero_mom <= zero_s4;
			out_s5.mass_inv <= inv_s4;
		end
	end

	assign prep = out_s5;

endmodule

// ===== rtl/core/fmsph_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module fmsph_sqrt import fmsph_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [SQ_BITS-1:0]   rad,
	output logic [WORD_BITS-1:0] root
);

	logic [SQ_BITS-1:0] rem_s [SQRT_STEPS];
	logic [SQ_BITS-1:0] res_s [SQRT_STEPS];
	logic [SQ_BITS-1:0] rem_in [SQRT_STEPS];
	logic [SQ_BITS-1:0] res_in [SQRT_STEPS];
	logic [SQ_BITS-1:0] rem_nx [SQRT_STEPS];
	logic [SQ_BITS-1:0] res_nx [SQRT_STEPS];

	always_comb begin
		rem_in[0] = rad;
		res_in[0] = '0;
		for (int k = 1; k < SQRT_STEPS; k++) begin
			rem_in[k] = rem_s[k-1];
			res_in[k] = res_s[k-1];
		end
	end

	always_comb begin
		logic [SQ_BITS-1:0] bitv, trial;
		bitv  = '0;
		trial = '0;
		for (int k = 0; k < SQRT_STEPS; k++) begin
			bitv  = SQ_BITS'(1) << (SQ_BITS - 2 - 2 * k);
			trial = res_in[k] + bitv;
			if (rem_in[k] >= trial) begin
				rem_nx[k] = rem_in[k] - trial;
				res_nx[k] = (res_in[k] >> 1) + bitv;
			end else begin
				rem_nx[k] = rem_in[k];
				res_nx[k] = res_in[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQRT_STEPS; k++) begin
				rem_s[k] <= rem_nx[k];
				res_s[k] <= res_nx[k];
			end
		end
	end

	assign root = res_s[SQRT_STEPS-1][WORD_BITS-1:0];

endmodule

// ===== rtl/core/fmsph_cordic.sv =====
// Pipelined CORDIC vectoring: angle of (x, y) in binary fractions of a turn.
module fmsph_cordic import fmsph_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [SQ_BITS-1:0] x_in,
	input  logic signed [SQ_BITS-1:0] y_in,
	output logic [ANGLE_BITS-1:0]     angle
);

	localparam turn_t HALF    = turn_t'(1) << (TURN_BITS - 1);
	localparam turn_t QUARTER = turn_t'(1) << (TURN_BITS - 2);
	localparam turn_t ROUND   = turn_t'(1) << (GUARD_BITS - 1);

	typedef struct packed {
		logic  spec;
		logic  base;
		turn_t spec_t;
	} ang_ctl_t;

	logic signed [SQ_BITS-1:0] xa, ya;
	logic [SQ_BITS-1:0] mx, my, mm;
	ang_ctl_t ctl;

	logic signed [SQ_BITS-1:0] xa_s1, ya_s1;
	chunk_bl_t cbl_s1;
	ang_ctl_t ctl_s1;

	logic signed [SQ_BITS-1:0] xa_s2, ya_s2;
	logic [BL_BITS-1:0] bl_s2;
	ang_ctl_t ctl_s2;

	logic signed [SQ_BITS-1:0] xw, yw;
	logic signed [CORDIC_BITS-1:0] x_s3, y_s3;
	ang_ctl_t ctl_s3;

	logic signed [CORDIC_BITS-1:0] cx_s [CORDIC_STEPS];
	logic signed [CORDIC_BITS-1:0] cy_s [CORDIC_STEPS];
	turn_t cz_s [CORDIC_STEPS];
	ang_ctl_t cc_s [CORDIC_STEPS];

	logic signed [CORDIC_BITS-1:0] cx_in [CORDIC_STEPS];
	logic signed [CORDIC_BITS-1:0] cy_in [CORDIC_STEPS];
	turn_t cz_in [CORDIC_STEPS];
	ang_ctl_t cc_in [CORDIC_STEPS];
	logic signed [CORDIC_BITS-1:0] cx_nx [CORDIC_STEPS];
	logic signed [CORDIC_BITS-1:0] cy_nx [CORDIC_STEPS];
	turn_t cz_nx [CORDIC_STEPS];

	turn_t t_fin;
	logic [ANGLE_BITS-1:0] angle_s;

	always_comb begin
		ctl.spec = (y_in == '0) || (x_in == '0);
		ctl.base = x_in[SQ_BITS-1];
		if (y_in == '0) begin
			ctl.spec_t = x_in[SQ_BITS-1] ? HALF : '0;
		end else begin
			ctl.spec_t = y_in[SQ_BITS-1] ? (HALF + QUARTER) : QUARTER;
		end
		xa = x_in[SQ_BITS-1] ? -x_in : x_in;
		ya = x_in[SQ_BITS-1] ? -y_in : y_in;
		mx = xa;
		my = ya[SQ_BITS-1] ? -ya : ya;
		mm = (mx > my) ? mx : my;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xa_s1  <= xa;
			ya_s1  <= ya;
			cbl_s1 <= chunk_bitlens(mm);
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xa_s2  <= xa_s1;
			ya_s2  <= ya_s1;
			bl_s2  <= bitlen_join(cbl_s1);
			ctl_s2 <= ctl_s1;
		end
	end

	always_comb begin
		if (bl_s2 > BL_BITS'(NORM_LEN)) begin
			xw = xa_s2 >>> (bl_s2 - BL_BITS'(NORM_LEN));
			yw = ya_s2 >>> (bl_s2 - BL_BITS'(NORM_LEN));
		end else begin
			xw = xa_s2 <<< (BL_BITS'(NORM_LEN) - bl_s2);
			yw = ya_s2 <<< (BL_BITS'(NORM_LEN) - bl_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3   <= xw[CORDIC_BITS-1:0];
			y_s3   <= yw[CORDIC_BITS-1:0];
			ctl_s3 <= ctl_s2;
		end
	end

	always_comb begin
		cx_in[0] = x_s3;
		cy_in[0] = y_s3;
		cz_in[0] = '0;
		cc_in[0] = ctl_s3;
		for (int k = 1; k < CORDIC_STEPS; k++) begin
			cx_in[k] = cx_s[k-1];
			cy_in[k] = cy_s[k-1];
			cz_in[k] = cz_s[k-1];
			cc_in[k] = cc_s[k-1];
		end
	end

	always_comb begin
		logic signed [CORDIC_BITS-1:0] xs, ys;
		xs = '0;
		ys = '0;
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			xs = cx_in[k] >>> k;
			ys = cy_in[k] >>> k;
			if (!cy_in[k][CORDIC_BITS-1] && cy_in[k] != '0) begin
				cx_nx[k] = cx_in[k] + ys;
				cy_nx[k] = cy_in[k] - xs;
				cz_nx[k] = cz_in[k] + atan_step(k);
			end else begin
				cx_nx[k] = cx_in[k] - ys;
				cy_nx[k] = cy_in[k] + xs;
				cz_nx[k] = cz_in[k] - atan_step(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < CORDIC_STEPS; k++) begin
				cx_s[k] <= cx_nx[k];
				cy_s[k] <= cy_nx[k];
				cz_s[k] <= cz_nx[k];
				cc_s[k] <= cc_in[k];
			end
		end
	end

	always_comb begin
		if (cc_s[CORDIC_STEPS-1].spec) begin
			t_fin = cc_s[CORDIC_STEPS-1].spec_t;
		end else begin
			t_fin = (cc_s[CORDIC_STEPS-1].base ? HALF : '0) + cz_s[CORDIC_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s <= ANGLE_BITS'((t_fin + ROUND) >> GUARD_BITS);
		end
	end

	assign angle = angle_s;

endmodule

// ===== rtl/core/four_momentum_to_spherical_unit.sv =====
// Top level of the four-momentum to spherical coordinate converter.
// Takes one four-momentum per clock and returns magnitude, transverse momentum,
// polar angle, azimuth and invariant mass through the prep stages, the 32-stage
// square root and the 34-stage CORDIC of the polar angle. Throughput is one
// transaction per cycle; when the output is held off the whole pipeline holds.
module four_momentum_to_spherical_unit import fmsph_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [IN_TDATA_BITS-1:0]  s_tdata,  // mom_x, mom_y, mom_z, energy
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_TDATA_BITS-1:0] m_tdata,  // mom_magnitude, mom_transverse, polar_angle, azimuth, inv_mass
	output logic [OUT_TUSER_BITS-1:0] m_tuser   // zero_momentum, mass_invalid
);

	localparam int FLAG_LAT = SQRT_STEPS + CORDIC_LAT;

	logic adv;
	logic [TOTAL_LAT-1:0] vld_s;
	prep_t prep;

	logic [WORD_BITS-1:0] mag_root, pt_root, mass_root, ps_root;
	logic [ANGLE_BITS-1:0] polar_raw, azim;

	logic signed [WORD_BITS-1:0] ax_d [SQRT_STEPS];
	logic signed [WORD_BITS-1:0] ay_d [SQRT_STEPS];
	logic signed [SQ_BITS-1:0]   zp_d [SQRT_STEPS];
	logic [1:0]                  flag_d [FLAG_LAT];
	logic [WORD_BITS-1:0]        mag_d [CORDIC_LAT];
	logic [WORD_BITS-1:0]        pt_d [CORDIC_LAT];
	logic [WORD_BITS-1:0]        mass_d [CORDIC_LAT];

	logic signed [SQ_BITS-1:0] az_x, az_y, po_y;
	logic [ANGLE_BITS-1:0] polar;

	assign adv      = !vld_s[TOTAL_LAT-1] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_s[TOTAL_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[TOTAL_LAT-2:0], s_tvalid};
		end
	end

	fmsph_prep u_prep (
		.clk    (clk),
		.en     (adv),
		.mom_x  (s_tdata[WORD_BITS-1:0]),
		.mom_y  (s_tdata[2*WORD_BITS-1:WORD_BITS]),
		.mom_z  (s_tdata[3*WORD_BITS-1:2*WORD_BITS]),
		.energy (s_tdata[4*WORD_BITS-1:3*WORD_BITS]),
		.prep   (prep)
	);

	fmsph_sqrt u_sqrt_mag  (.clk(clk), .en(adv), .rad(prep.p_sq),    .root(mag_root));
	fmsph_sqrt u_sqrt_pt   (.clk(clk), .en(adv), .rad(prep.pt_sq),   .root(pt_root));
	fmsph_sqrt u_sqrt_mass (.clk(clk), .en(adv), .rad(prep.mass_sq), .root(mass_root));
	fmsph_sqrt u_sqrt_ps   (.clk(clk), .en(adv), .rad(prep.ps),      .root(ps_root));

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_d[0]   <= prep.x;
			ay_d[0]   <= prep.y;
			zp_d[0]   <= prep.zpart;
			flag_d[0] <= {prep.mass_inv, prep.zero_mom};
			mag_d[0]  <= mag_root;
			pt_d[0]   <= pt_root;
			mass_d[0] <= mass_root;
			for (int k = 1; k < SQRT_STEPS; k++) begin
				ax_d[k] <= ax_d[k-1];
				ay_d[k] <= ay_d[k-1];
				zp_d[k] <= zp_d[k-1];
			end
			for (int k = 1; k < FLAG_LAT; k++) begin
				flag_d[k] <= flag_d[k-1];
			end
			for (int k = 1; k < CORDIC_LAT; k++) begin
				mag_d[k]  <= mag_d[k-1];
				pt_d[k]   <= pt_d[k-1];
				mass_d[k] <= mass_d[k-1];
			end
		end
	end

	assign az_x = {{WORD_BITS{ax_d[SQRT_STEPS-1][WORD_BITS-1]}}, ax_d[SQRT_STEPS-1]};
	assign az_y = {{WORD_BITS{ay_d[SQRT_STEPS-1][WORD_BITS-1]}}, ay_d[SQRT_STEPS-1]};
	assign po_y = $signed({{WORD_BITS{1'b0}}, ps_root});

	fmsph_cordic u_cordic_polar (
		.clk   (clk),
		.en    (adv),
		.x_in  (zp_d[SQRT_STEPS-1]),
		.y_in  (po_y),
		.angle (polar_raw)
	);

	fmsph_cordic u_cordic_azim (
		.clk   (clk),
		.en    (adv),
		.x_in  (az_x),
		.y_in  (az_y),
		.angle (azim)
	);

	assign polar   = flag_d[FLAG_LAT-1][0] ? '0 : polar_raw;
	assign m_tdata = {mass_d[CORDIC_LAT-1], azim, polar, pt_d[CORDIC_LAT-1],
		mag_d[CORDIC_LAT-1]};
	assign m_tuser = flag_d[FLAG_LAT-1];

	a_zero_angles: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[111:64] == 48'd0)
		else $error("zero momentum with nonzero angle");

	a_zero_mag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[63:0] == 64'd0)
		else $error("zero momentum with nonzero magnitude");

	a_mass_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[143:112] == 32'd0)
		else $error("invalid mass not cleared");

	a_polar_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[87:64] <= 24'h800000)
		else $error("polar angle beyond half turn");

endmodule
